// ===== hdl/nrmc_pkg.sv =====
package nrmc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] HEX_ALPHA_BIAS = 8'd55;

    localparam logic [3:0] FIELD_TIME  = 4'd1;
    localparam logic [3:0] FIELD_FIX   = 4'd2;
    localparam logic [3:0] FIELD_DATE  = 4'd9;
    localparam logic [3:0] FIELD_MAX   = 4'd15;
    localparam logic [2:0] DIGIT_COUNT = 3'd6;
    localparam logic [2:0] POS_MAX     = 3'd7;
    localparam logic [2:0] HDR_FIRST   = 3'd3;
    localparam logic [2:0] HDR_MID     = 3'd4;
    localparam logic [2:0] HDR_LAST    = 3'd5;

    localparam logic KIND_RMC = 1'b0;

    typedef enum logic [1:0] {
        PH_BODY = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        logic        in_sentence;
        logic [2:0]  header_position;
        logic        header_match;
        logic [3:0]  field_count;
        logic [2:0]  field_position;
        logic [7:0]  running_xor;
        phase_t      checksum_phase;
        logic [3:0]  received_high_nibble;
        logic [23:0] time_digits;
        logic [23:0] date_digits;
        logic        valid_seen;
        logic        digit_error;
    } parse_state_t;

    typedef struct packed {
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic [6:0] day;
        logic [6:0] month;
        logic [6:0] year;
        logic       fix_valid;
        logic       checksum_ok;
        logic       format_error;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = (c > CH_NINE) ? (c - HEX_ALPHA_BIAS) : (c - CH_ZERO);
        return v[3:0];
    endfunction

    // two bcd-like nibbles to binary, kept to 7 bits
    function automatic logic [6:0] pair_value(input logic [3:0] hi, input logic [3:0] lo);
        logic [7:0] v;
        v = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
        return v[6:0];
    endfunction

endpackage

// ===== hdl/nrmc_byte_step.sv =====
module nrmc_byte_step
    import nrmc_pkg::*;
(
    input  parse_state_t st,
    input  logic [7:0]   rx_byte,
    input  logic         kind,
    output parse_state_t st_next,
    output result_t      result,
    output logic         result_fire
);

    logic       rmc;
    logic [2:0] hp;
    logic [7:0] want;
    logic       close_err;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] rx_sum;

    always_comb
    begin
        rmc       = (kind == KIND_RMC);
        hp        = st.header_position + 3'd1;
        is_digit  = rx_byte inside {[CH_ZERO:CH_NINE]};
        digit     = is_digit ? rx_byte[3:0] : 4'd0;
        close_err = rmc && (st.field_count == FIELD_TIME || st.field_count == FIELD_DATE)
                    && (st.field_position < DIGIT_COUNT);
        rx_sum    = {st.received_high_nibble, hex_value(rx_byte)};
        case (hp)
            HDR_FIRST: want = rmc ? CH_R : CH_G;
            HDR_MID:   want = rmc ? CH_M : CH_G;
            HDR_LAST:  want = rmc ? CH_C : CH_A;
            default:   want = 8'h00;
        endcase

        st_next     = st;
        result      = '0;
        result_fire = 1'b0;

        if (rx_byte == CH_DOLLAR)
        begin
            st_next             = '0;
            st_next.in_sentence = 1'b1;
        end
        else if (!st.in_sentence)
        begin
            st_next = st;
        end
        else if (!st.header_match)
        begin
            if (rx_byte == CH_STAR)
            begin
                st_next = '0;
            end
            else if (hp >= HDR_FIRST && rx_byte != want)
            begin
                st_next = '0;
            end
            else
            begin
                st_next.header_position = hp;
                st_next.running_xor     = st.running_xor ^ rx_byte;
                if (hp == HDR_LAST)
                begin
                    st_next.header_match = 1'b1;
                end
            end
        end
        else
        begin
            case (st.checksum_phase)
                PH_HIGH:
                begin
                    st_next.received_high_nibble = hex_value(rx_byte);
                    st_next.checksum_phase       = PH_LOW;
                end
                PH_LOW:
                begin
                    result_fire        = 1'b1;
                    result.checksum_ok = (rx_sum == st.running_xor);
                    if (rmc)
                    begin
                        result.hour   = pair_value(st.time_digits[23:20], st.time_digits[19:16]);
                        result.minute = pair_value(st.time_digits[15:12], st.time_digits[11:8]);
                        result.second = pair_value(st.time_digits[7:4], st.time_digits[3:0]);
                        result.day    = pair_value(st.date_digits[23:20], st.date_digits[19:16]);
                        result.month  = pair_value(st.date_digits[15:12], st.date_digits[11:8]);
                        result.year   = pair_value(st.date_digits[7:4], st.date_digits[3:0]);
                        result.fix_valid    = st.valid_seen;
                        result.format_error = st.digit_error;
                    end
                    st_next = '0;
                end
                default:
                begin
                    if (rx_byte == CH_STAR)
                    begin
                        st_next.digit_error    = st.digit_error | close_err
                                                 | (rmc && st.field_count < FIELD_DATE);
                        st_next.checksum_phase = PH_HIGH;
                    end
                    else
                    begin
                        st_next.running_xor = st.running_xor ^ rx_byte;
                        if (rx_byte == CH_COMMA)
                        begin
                            st_next.digit_error = st.digit_error | close_err;
                            if (st.field_count < FIELD_MAX)
                            begin
                                st_next.field_count = st.field_count + 4'd1;
                            end
                            st_next.field_position = 3'd0;
                        end
                        else
                        begin
                            if (rmc && st.field_position < DIGIT_COUNT &&
                                (st.field_count == FIELD_TIME || st.field_count == FIELD_DATE))
                            begin
                                if (!is_digit)
                                begin
                                    st_next.digit_error = 1'b1;
                                end
                                // first digit sits in the top nibble
                                for (int i = 0; i < 6; i++)
                                begin
                                    if (st.field_position == 3'(i))
                                    begin
                                        if (st.field_count == FIELD_TIME)
                                        begin
                                            st_next.time_digits[23 - 4*i -: 4] = digit;
                                        end
                                        else
                                        begin
                                            st_next.date_digits[23 - 4*i -: 4] = digit;
                                        end
                                    end
                                end
                            end
                            if (rmc && st.field_count == FIELD_FIX && st.field_position == 3'd0)
                            begin
                                st_next.valid_seen = (rx_byte == CH_A);
                            end
                            if (st.field_position < POS_MAX)
                            begin
                                st_next.field_position = st.field_position + 3'd1;
                            end
                        end
                    end
                end
            endcase
        end
    end

endmodule

// ===== hdl/nmea_rmc_sentence_parser_core.sv =====
// channel  | handshake                | payload
// cfg      | cfg_valid / cfg_ready    | cfg_data (sentence kind, 0 = rmc, 1 = gga)
// in       | in_valid / in_ready      | rx_byte
// out      | out_valid / out_ready    | hour .. year, fix_valid, checksum_ok, format_error
//
// one byte per cycle while no result is stalled on out_ready; each byte passes through
// the input register, and the last byte of a sentence loads the result register.
// the input register and the result register decouple the two sides, so a
// stalled result only holds the parse stage when the next byte would replace it.
// reset clears the parse state, the mode and both valid flags; cfg_ready is always high.
module nmea_rmc_sentence_parser_core
    import nrmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] hour,
    output logic [6:0] minute,
    output logic [6:0] second,
    output logic [6:0] day,
    output logic [6:0] month,
    output logic [6:0] year,
    output logic       fix_valid,
    output logic       checksum_ok,
    output logic       format_error
);

    logic         kind_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    parse_state_t st_reg;
    parse_state_t st_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      res_reg;
    result_t      res_next;
    logic         res_fire;
    logic         advance;

    nrmc_byte_step u_step
    (
        .st          (st_reg),
        .rx_byte     (in_byte_reg),
        .kind        (kind_reg),
        .st_next     (st_next),
        .result      (res_next),
        .result_fire (res_fire)
    );

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!res_fire || !out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    always_comb
    begin
        if (advance && res_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_RMC;
            in_valid_reg  <= 1'b0;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                kind_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && res_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hour         = res_reg.hour;
    assign minute       = res_reg.minute;
    assign second       = res_reg.second;
    assign day          = res_reg.day;
    assign month        = res_reg.month;
    assign year         = res_reg.year;
    assign fix_valid    = res_reg.fix_valid;
    assign checksum_ok  = res_reg.checksum_ok;
    assign format_error = res_reg.format_error;

endmodule
